// ----- rtl/core/rgas_pkg.sv -----
// Shared types and constants for the rigid 2D alignment gradient sum unit.
// No dependencies; imported by every other file in rtl/core.
package rgas_pkg;

    localparam int COORD_W      = 24;
    localparam int TRIG_W       = 16;
    localparam int TRIG_FRAC    = 14;
    localparam int SUM_W        = 64;

    // intermediate widths of the datapath
    localparam int PROD_W = COORD_W + TRIG_W;            // coord * trig
    localparam int ROT_W  = PROD_W + 1 - TRIG_FRAC;      // rotated coord
    localparam int OFF_W  = COORD_W + 1;                 // shift - target
    localparam int RES_W  = ROT_W + 1;                   // residual
    localparam int MUL_W  = RES_W + ROT_W;               // residual * rotated
    localparam int DIFF_W = MUL_W + 1;                   // cross product

    localparam int PAIR_Q_DEPTH = 4;
    localparam int PAIR_Q_PTR_W = $clog2(PAIR_Q_DEPTH);
    localparam int PAIR_Q_CNT_W = $clog2(PAIR_Q_DEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_COS     = 2'd0,
        REG_SIN     = 2'd1,
        REG_SHIFT_X = 2'd2,
        REG_SHIFT_Y = 2'd3
    } t_reg_idx;

    localparam logic [TRIG_W-1:0] COS_RESET = TRIG_W'(16384);

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic               last_point;
    } t_pair;

    // head of the pair queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_pair_head;

    typedef struct packed {
        logic [TRIG_W-1:0]  cos_rotation;
        logic [TRIG_W-1:0]  sin_rotation;
        logic [COORD_W-1:0] shift_x;
        logic [COORD_W-1:0] shift_y;
    } t_cfg;

endpackage

// ----- rtl/core/rgas_if.sv -----
// Handshake channels for point pairs in and gradient sums out.
// Depends on rgas_pkg for field widths.
interface rgas_pair_if import rgas_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic               last_point;

    modport source (output valid, src_x, src_y, dst_x, dst_y, last_point, input ready);
    modport sink   (input valid, src_x, src_y, dst_x, dst_y, last_point, output ready);
endinterface

interface rgas_grad_if import rgas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] grad_angle;
    logic [SUM_W-1:0] grad_dx;
    logic [SUM_W-1:0] grad_dy;
    logic             overflow;

    modport source (output valid, grad_angle, grad_dx, grad_dy, overflow, input ready);
    modport sink   (input valid, grad_angle, grad_dx, grad_dy, overflow, output ready);
endinterface

// ----- rtl/core/rgas_front.sv -----
// Front end: takes point pairs off the input channel into a short queue.
// Depends on rgas_pkg and rgas_pair_if.
module rgas_front import rgas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgas_pair_if.sink  i_pair,
    input  logic       i_pop,
    output t_pair_head o_head
);

    t_pair                   r_q [PAIR_Q_DEPTH];
    logic [PAIR_Q_PTR_W-1:0] r_wr_ptr;
    logic [PAIR_Q_PTR_W-1:0] r_rd_ptr;
    logic [PAIR_Q_CNT_W-1:0] r_count;
    logic                    push;
    logic                    pop;
    t_pair                   in_pair;

    assign i_pair.ready = (r_count != PAIR_Q_CNT_W'(PAIR_Q_DEPTH));
    assign push         = i_pair.valid && i_pair.ready;
    assign pop          = i_pop && (r_count != '0);

    assign in_pair.src_x      = i_pair.src_x;
    assign in_pair.src_y      = i_pair.src_y;
    assign in_pair.dst_x      = i_pair.dst_x;
    assign in_pair.dst_y      = i_pair.dst_y;
    assign in_pair.last_point = i_pair.last_point;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.pair  = r_q[r_rd_ptr];

endmodule

// ----- rtl/core/rgas_back.sv -----
// Back end: rotate, residual, gradient terms and saturating sums, one pair per cycle while no result waits.
// Depends on rgas_pkg and rgas_grad_if; fed from the rgas_front queue.
module rgas_back import rgas_pkg::*; #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_pair_head  i_head,
    output logic        o_pop,
    rgas_grad_if.source o_grad
);

    localparam logic signed [PROD_W:0] TRIG_HALF =
        (PROD_W+1)'(1) << (TRIG_FRAC - 1);
    localparam logic signed [DIFF_W-1:0] COORD_HALF =
        DIFF_W'(1) << (COORD_FRAC_BITS - 1);

    typedef struct packed {
        logic             ovf;
        logic [SUM_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_add(input logic [SUM_W-1:0] acc,
                                     input logic [SUM_W-1:0] term);
        logic [SUM_W:0] s;
        t_sat           r;
        s     = {acc[SUM_W-1], acc} + {term[SUM_W-1], term};
        r.ovf = s[SUM_W] ^ s[SUM_W-1];
        if (r.ovf) begin
            r.val = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r.val = s[SUM_W-1:0];
        end
        return r;
    endfunction

    logic adv;

    // stage 1: rotation products, offsets
    logic                      r_s1_valid, r_s1_last;
    logic signed [PROD_W-1:0]  r_s1_xc, r_s1_ys, r_s1_xs, r_s1_yc;
    logic signed [OFF_W-1:0]   r_s1_off_x, r_s1_off_y;
    // stage 2: rotated point and residual
    logic                      r_s2_valid, r_s2_last;
    logic signed [ROT_W-1:0]   r_s2_rot_x, r_s2_rot_y;
    logic signed [RES_W-1:0]   r_s2_res_x, r_s2_res_y;
    // stage 3: cross products
    logic                      r_s3_valid, r_s3_last;
    logic signed [MUL_W-1:0]   r_s3_ma, r_s3_mb;
    logic signed [RES_W-1:0]   r_s3_res_x, r_s3_res_y;
    // stage 4: gradient terms
    logic                      r_s4_valid, r_s4_last;
    logic signed [DIFF_W:0]    r_s4_d_angle;
    logic signed [RES_W:0]     r_s4_d_dx, r_s4_d_dy;

    logic signed [PROD_W:0]    rot_x_full, rot_y_full;
    logic signed [ROT_W-1:0]   n_rot_x, n_rot_y;
    logic signed [DIFF_W-1:0]  cross_prod, cross_rnd;
    t_sat                      acc_angle, acc_dx, acc_dy;
    logic                      set_ovf;

    logic [SUM_W-1:0] r_sum_angle, r_sum_dx, r_sum_dy;
    logic             r_sat_flag;

    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_angle, r_out_dx, r_out_dy;
    logic             r_out_ovf;

    // only a finished set with the result slot still full holds the pipe
    assign adv   = !(r_s4_valid && r_s4_last && r_out_valid && !o_grad.ready);
    assign o_pop = adv && i_head.valid;

    assign rot_x_full = (PROD_W+1)'(r_s1_xc) - (PROD_W+1)'(r_s1_ys) + TRIG_HALF;
    assign rot_y_full = (PROD_W+1)'(r_s1_xs) + (PROD_W+1)'(r_s1_yc) + TRIG_HALF;
    assign n_rot_x    = rot_x_full[PROD_W:TRIG_FRAC];
    assign n_rot_y    = rot_y_full[PROD_W:TRIG_FRAC];

    assign cross_prod = DIFF_W'(r_s3_ma) - DIFF_W'(r_s3_mb);
    assign cross_rnd  = (cross_prod + COORD_HALF) >>> COORD_FRAC_BITS;

    assign acc_angle = sat_add(r_sum_angle, SUM_W'(r_s4_d_angle));
    assign acc_dx    = sat_add(r_sum_dx, SUM_W'(r_s4_d_dx));
    assign acc_dy    = sat_add(r_sum_dy, SUM_W'(r_s4_d_dy));
    assign set_ovf   = r_sat_flag || acc_angle.ovf || acc_dx.ovf || acc_dy.ovf;

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last  <= i_head.pair.last_point;
            r_s1_xc    <= $signed(i_head.pair.src_x) * $signed(i_cfg.cos_rotation);
            r_s1_ys    <= $signed(i_head.pair.src_y) * $signed(i_cfg.sin_rotation);
            r_s1_xs    <= $signed(i_head.pair.src_x) * $signed(i_cfg.sin_rotation);
            r_s1_yc    <= $signed(i_head.pair.src_y) * $signed(i_cfg.cos_rotation);
            r_s1_off_x <= OFF_W'($signed(i_cfg.shift_x)) - OFF_W'($signed(i_head.pair.dst_x));
            r_s1_off_y <= OFF_W'($signed(i_cfg.shift_y)) - OFF_W'($signed(i_head.pair.dst_y));

            r_s2_last  <= r_s1_last;
            r_s2_rot_x <= n_rot_x;
            r_s2_rot_y <= n_rot_y;
            r_s2_res_x <= RES_W'(n_rot_x) + RES_W'(r_s1_off_x);
            r_s2_res_y <= RES_W'(n_rot_y) + RES_W'(r_s1_off_y);

            r_s3_last  <= r_s2_last;
            r_s3_ma    <= r_s2_res_y * r_s2_rot_x;
            r_s3_mb    <= r_s2_res_x * r_s2_rot_y;
            r_s3_res_x <= r_s2_res_x;
            r_s3_res_y <= r_s2_res_y;

            r_s4_last    <= r_s3_last;
            r_s4_d_angle <= {cross_rnd, 1'b0};
            r_s4_d_dx    <= {r_s3_res_x, 1'b0};
            r_s4_d_dy    <= {r_s3_res_y, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grad.ready || !r_out_valid) begin
            if (adv && r_s4_valid && r_s4_last) begin
                r_out_angle <= acc_angle.val;
                r_out_dx    <= acc_dx.val;
                r_out_dy    <= acc_dy.val;
                r_out_ovf   <= set_ovf;
            end
        end
    end

    // control and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_sum_angle <= '0;
            r_sum_dx    <= '0;
            r_sum_dy    <= '0;
            r_sat_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv && r_s4_valid && r_s4_last) begin
                r_out_valid <= 1'b1;
            end else if (o_grad.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_s1_valid <= i_head.valid;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                if (r_s4_valid) begin
                    if (r_s4_last) begin
                        r_sum_angle <= '0;
                        r_sum_dx    <= '0;
                        r_sum_dy    <= '0;
                        r_sat_flag  <= 1'b0;
                    end else begin
                        r_sum_angle <= acc_angle.val;
                        r_sum_dx    <= acc_dx.val;
                        r_sum_dy    <= acc_dy.val;
                        r_sat_flag  <= set_ovf;
                    end
                end
            end
        end
    end

    assign o_grad.valid      = r_out_valid;
    assign o_grad.grad_angle = r_out_angle;
    assign o_grad.grad_dx    = r_out_dx;
    assign o_grad.grad_dy    = r_out_dy;
    assign o_grad.overflow   = r_out_ovf;

endmodule

// ----- rtl/core/rigid_2d_align_gradient_sum_unit.sv -----
// Rigid 2D alignment gradient sum unit: top level with APB register bank.
// Depends on rgas_pkg, rgas_if, rgas_front and rgas_back.
// Throughput: one point pair per cycle while no result waits; only the saturating 64-bit accumulate loops.
// Path: a last pair's sums reach o_grad through the queue, four datapath stages and the
// result register; a waiting result holds the pipe.
// Reset (sync, active low) empties queue and pipe, clears sums, loads cos 1.0, sin 0.
module rigid_2d_align_gradient_sum_unit import rgas_pkg::*; #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rgas_pair_if.sink             i_pair,
    rgas_grad_if.source           o_grad
);

    t_cfg       r_cfg;
    t_pair_head head;
    logic       pop;
    t_reg_idx   reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_rotation <= COS_RESET;
            r_cfg.sin_rotation <= '0;
            r_cfg.shift_x      <= '0;
            r_cfg.shift_y      <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COS:     r_cfg.cos_rotation <= pwdata[TRIG_W-1:0];
                REG_SIN:     r_cfg.sin_rotation <= pwdata[TRIG_W-1:0];
                REG_SHIFT_X: r_cfg.shift_x      <= pwdata[COORD_W-1:0];
                REG_SHIFT_Y: r_cfg.shift_y      <= pwdata[COORD_W-1:0];
                default:     r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COS:     prdata = APB_DATA_W'($signed(r_cfg.cos_rotation));
            REG_SIN:     prdata = APB_DATA_W'($signed(r_cfg.sin_rotation));
            REG_SHIFT_X: prdata = APB_DATA_W'($signed(r_cfg.shift_x));
            REG_SHIFT_Y: prdata = APB_DATA_W'($signed(r_cfg.shift_y));
            default:     prdata = '0;
        endcase
    end

    rgas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (i_pair),
        .i_pop   (pop),
        .o_head  (head)
    );

    rgas_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_grad  (o_grad)
    );

endmodule

// ----- bench/rigid_2d_align_gradient_sum_checker.sv -----
// Checker for the rigid 2D alignment gradient sum unit: watches the register port and
// both channels, predicts the gradient sums per set and compares each result word.
// Depends on rgas_pkg and the rgas_pair_if / rgas_grad_if interfaces.
module rigid_2d_align_gradient_sum_checker import rgas_pkg::*; #(
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    rgas_pair_if                  i_pair,
    rgas_grad_if                  i_grad,
    output int                    o_fail_cnt,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SUM_W-1:0] angle;
        logic [SUM_W-1:0] dx;
        logic [SUM_W-1:0] dy;
        logic             ovf;
    } t_grad_sums;

    longint     cos_q, sin_q, shift_x_q, shift_y_q;
    longint     angle_sum, dx_sum, dy_sum;
    bit         sum_saturated;
    t_grad_sums sums_due[$];

    // floor((v + half) / 2^n): arithmetic shift on a signed longint floors
    function automatic longint round_shr(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sat_add(input longint acc, input longint t, inout bit sat);
        logic signed [SUM_W:0] wide;
        wide = acc;
        wide = wide + t;
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            sat = 1'b1;
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return wide[SUM_W-1:0];
    endfunction

    task automatic accumulate_pair();
        longint sx, sy, tx, ty, rot_x, rot_y, res_x, res_y, d_angle;
        t_grad_sums done;
        sx = $signed(i_pair.src_x);
        sy = $signed(i_pair.src_y);
        tx = $signed(i_pair.dst_x);
        ty = $signed(i_pair.dst_y);
        rot_x = round_shr(sx * cos_q - sy * sin_q, TRIG_FRAC);
        rot_y = round_shr(sx * sin_q + sy * cos_q, TRIG_FRAC);
        res_x = rot_x + shift_x_q - tx;
        res_y = rot_y + shift_y_q - ty;
        d_angle = 2 * round_shr(res_y * rot_x - res_x * rot_y, COORD_FRAC_BITS);
        angle_sum = sat_add(angle_sum, d_angle, sum_saturated);
        dx_sum    = sat_add(dx_sum, 2 * res_x, sum_saturated);
        dy_sum    = sat_add(dy_sum, 2 * res_y, sum_saturated);
        if (i_pair.last_point) begin
            done.angle = angle_sum;
            done.dx    = dx_sum;
            done.dy    = dy_sum;
            done.ovf   = sum_saturated;
            sums_due.push_back(done);
            angle_sum     = 0;
            dx_sum        = 0;
            dy_sum        = 0;
            sum_saturated = 1'b0;
        end
    endtask

    task automatic compare_sums();
        t_grad_sums want;
        if (sums_due.size() == 0) begin
            $error("grad word with no set outstanding: angle %0d dx %0d dy %0d",
                   $signed(i_grad.grad_angle), $signed(i_grad.grad_dx),
                   $signed(i_grad.grad_dy));
            o_fail_cnt++;
            return;
        end
        want = sums_due.pop_front();
        if (i_grad.grad_angle !== want.angle) begin
            $error("grad_angle: expected %0d, actual %0d",
                   $signed(want.angle), $signed(i_grad.grad_angle));
            o_fail_cnt++;
        end
        if (i_grad.grad_dx !== want.dx) begin
            $error("grad_dx: expected %0d, actual %0d",
                   $signed(want.dx), $signed(i_grad.grad_dx));
            o_fail_cnt++;
        end
        if (i_grad.grad_dy !== want.dy) begin
            $error("grad_dy: expected %0d, actual %0d",
                   $signed(want.dy), $signed(i_grad.grad_dy));
            o_fail_cnt++;
        end
        if (i_grad.overflow !== want.ovf) begin
            $error("overflow: expected %0b, actual %0b", want.ovf, i_grad.overflow);
            o_fail_cnt++;
        end
    endtask

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cos_q         = longint'(signed'(COS_RESET));
            sin_q         = 0;
            shift_x_q     = 0;
            shift_y_q     = 0;
            angle_sum     = 0;
            dx_sum        = 0;
            dy_sum        = 0;
            sum_saturated = 1'b0;
            sums_due.delete();
        end else begin
            if (i_grad.valid && i_grad.ready) begin
                compare_sums();
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
                    REG_COS:     cos_q     = $signed(pwdata[TRIG_W-1:0]);
                    REG_SIN:     sin_q     = $signed(pwdata[TRIG_W-1:0]);
                    REG_SHIFT_X: shift_x_q = $signed(pwdata[COORD_W-1:0]);
                    REG_SHIFT_Y: shift_y_q = $signed(pwdata[COORD_W-1:0]);
                    default: ;
                endcase
            end
            if (i_pair.valid && i_pair.ready) begin
                accumulate_pair();
            end
        end
        o_pending = sums_due.size();
    end

endmodule

// ----- bench/rigid_2d_align_gradient_sum_unit_tb.sv -----
// Top of the bench for the rigid 2D alignment gradient sum unit: clock, reset,
// register writes, point pair stimulus, result back-pressure and the verdict.
// Depends on rgas_pkg, the rgas interfaces, the unit and its checker.
module rigid_2d_align_gradient_sum_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgas_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_PAIRS = 1450;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [TRIG_W-1:0]  TRIG_MAX  = {1'b0, {(TRIG_W-1){1'b1}}};
    localparam logic [TRIG_W-1:0]  TRIG_MIN  = {1'b1, {(TRIG_W-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int src_idle_pct;
    int rcv_idle_pct;
    int cycle_cnt;
    int mismatch_cnt;
    int sums_pending;

    rgas_pair_if pair_ch ();
    rgas_grad_if grad_ch ();

    rigid_2d_align_gradient_sum_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pair  (pair_ch),
        .o_grad  (grad_ch)
    );

    rigid_2d_align_gradient_sum_checker sum_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .i_pair     (pair_ch),
        .i_grad     (grad_ch),
        .o_fail_cnt (mismatch_cnt),
        .o_pending  (sums_pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        grad_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3, 4: return COORD_W'($urandom_range(8192) - 4096);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [TRIG_W-1:0] rand_trig();
        case ($urandom_range(7))
            0: return TRIG_MIN;
            1: return TRIG_MAX;
            2: return TRIG_W'(16384);
            3: return TRIG_W'(-16384);
            4: return TRIG_W'($urandom);
            default: return TRIG_W'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin
                src_idle_pct = 10;
                rcv_idle_pct = 71;
            end
            1: begin
                src_idle_pct = 71;
                rcv_idle_pct = 10;
            end
            default: begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endfunction

    // all tasks below are entered and left at a falling edge
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are junk the register should ignore
    task automatic load_pose(input logic [TRIG_W-1:0] c, input logic [TRIG_W-1:0] s,
                             input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        logic [APB_DATA_W-1:0] w;
        w = $urandom;
        w[TRIG_W-1:0] = c;
        write_reg(REG_COS, w);
        w = $urandom;
        w[TRIG_W-1:0] = s;
        write_reg(REG_SIN, w);
        w = $urandom;
        w[COORD_W-1:0] = tx;
        write_reg(REG_SHIFT_X, w);
        w = $urandom;
        w[COORD_W-1:0] = ty;
        write_reg(REG_SHIFT_Y, w);
    endtask

    // valid stays up after a word is taken; settle() lowers it, as does the next call when it idles
    task automatic send_pair(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy,
                             input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pair_ch.valid      <= 1'b1;
        pair_ch.src_x      <= sx;
        pair_ch.src_y      <= sy;
        pair_ch.dst_x      <= dx;
        pair_ch.dst_y      <= dy;
        pair_ch.last_point <= last;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for every predicted set, then let a trailing partial set clear the pipe
    task automatic settle();
        pair_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sums_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int set_left;
        int phase_len;
        int r;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pair_ch.valid      = 1'b0;
        pair_ch.src_x      = '0;
        pair_ch.src_y      = '0;
        pair_ch.dst_x      = '0;
        pair_ch.dst_y      = '0;
        pair_ch.last_point = 1'b0;
        grad_ch.ready      = 1'b0;
        cycle_cnt          = 0;
        set_idling(0);

        // rising edges with reset held, released on the next falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset pose: identity rotation, no shift
        send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
        send_pair('0, '0, '0, '0, 1'b1);
        send_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_pair(COORD_MIN, COORD_MAX, '0, '0, 1'b1);
        // cross product of exactly plus and minus one half
        send_pair(COORD_W'(1), '0, '0, COORD_W'(-2048), 1'b1);
        send_pair(COORD_W'(1), '0, '0, COORD_W'(2048), 1'b1);
        settle();

        // cosine one half: rotation rounding ties
        load_pose(TRIG_W'(8192), '0, '0, '0);
        send_pair(COORD_W'(1), '0, '0, '0, 1'b1);
        send_pair(COORD_W'(-1), '0, '0, '0, 1'b1);
        send_pair('0, COORD_W'(1), '0, '0, 1'b1);
        send_pair('0, COORD_W'(-1), '0, '0, 1'b1);
        settle();

        // registers at the two's complement extremes
        load_pose(TRIG_MIN, TRIG_MIN, COORD_MAX, COORD_MIN);
        send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_pair(COORD_MAX, COORD_MIN, '0, COORD_MAX, 1'b1);
        settle();

        load_pose(TRIG_MAX, TRIG_MAX, COORD_MIN, COORD_MAX);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);
        send_pair(COORD_MAX, COORD_MIN, COORD_MAX, '0, 1'b0);
        send_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
        settle();

        // random sets; an open set may run on across a pose change
        sent     = 0;
        set_left = 0;
        while (sent < RANDOM_PAIRS) begin
            set_idling(sent * 3 / RANDOM_PAIRS);
            load_pose(rand_trig(), rand_trig(), rand_coord(), rand_coord());
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) begin
                if (set_left == 0) begin
                    r = $urandom_range(99);
                    if (r < 60) set_left = $urandom_range(1, 6);
                    else if (r < 90) set_left = $urandom_range(7, 24);
                    else set_left = $urandom_range(25, 64);
                end
                send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          set_left == 1);
                set_left--;
                sent++;
            end
            settle();
        end
        if (set_left != 0) begin
            send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
        end
        settle();

        if (sums_pending != 0) begin
            $error("%0d predicted sets never came out", sums_pending);
        end
        if (mismatch_cnt == 0 && sums_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
